[hdl/tlik_pkg.sv]
// Shared constants, types and the arctangent table of the two-link leg solver.
package tlik_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STAGES  = 32;
   localparam int ANGLE_W      = 28;
   localparam int CORDIC_W     = 34;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24 = 28'sd26353589;

   localparam logic [1:0] CSR_UPPER_LEN = 2'd0;
   localparam logic [1:0] CSR_LOWER_LEN = 2'd1;
   localparam logic [1:0] CSR_HIP_OFF   = 2'd2;
   localparam logic [1:0] CSR_KNEE_OFF  = 2'd3;

   typedef logic signed [ANGLE_W-1:0] angle_type;

   // sideband that rides along the pipeline with each request
   typedef struct packed {
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic               up;
      logic               fail;
   } side_type;

   // atan(2^-i) in Q24 radians
   function automatic angle_type atan_q24(input int i);
      angle_type a;
      case (i)
         0:  a = 28'sd13176795;
         1:  a = 28'sd7778716;
         2:  a = 28'sd4110060;
         3:  a = 28'sd2086331;
         4:  a = 28'sd1047214;
         5:  a = 28'sd524117;
         6:  a = 28'sd262123;
         7:  a = 28'sd131069;
         8:  a = 28'sd65536;
         9:  a = 28'sd32768;
         10: a = 28'sd16384;
         11: a = 28'sd8192;
         12: a = 28'sd4096;
         13: a = 28'sd2048;
         14: a = 28'sd1024;
         15: a = 28'sd512;
         16: a = 28'sd256;
         17: a = 28'sd128;
         18: a = 28'sd64;
         19: a = 28'sd32;
         20: a = 28'sd16;
         21: a = 28'sd8;
         22: a = 28'sd4;
         23: a = 28'sd2;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

[hdl/tlik_isqrt.sv]
// Pipelined integer square root, two radicand bits per stage.
module tlik_isqrt (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   import tlik_pkg::*;

   logic [63:0] rem_ff [1:SQRT_STAGES];
   logic [63:0] res_ff [1:SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] rem_cur, res_cur;
      logic [63:0] trial;
      if (k == 0) begin : g_first
         assign rem_cur = radicand;
         assign res_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k];
         assign res_cur = res_ff[k];
      end
      assign trial = res_cur + BIT;
      always_ff @(posedge clock) begin
         if (enable) begin
            if (rem_cur >= trial) begin
               rem_ff[k+1] <= rem_cur - trial;
               res_ff[k+1] <= (res_cur >> 1) + BIT;
            end else begin
               rem_ff[k+1] <= rem_cur;
               res_ff[k+1] <= res_cur >> 1;
            end
         end
      end
   end

   assign root = res_ff[SQRT_STAGES][31:0];

endmodule

[hdl/tlik_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(y, x) in Q24 radians.
module tlik_cordic (
   input  logic                      clock,
   input  logic                      enable,
   input  logic signed [31:0]        in_x,
   input  logic signed [31:0]        in_y,
   output logic signed [tlik_pkg::ANGLE_W-1:0] angle
);
   import tlik_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_W-1:0] y_ff [CORDIC_STEPS+1];
   angle_type                  z_ff [CORDIC_STEPS+1];
   logic                       zero_ff [CORDIC_STEPS+1];

   logic signed [CORDIC_W-1:0] wx, wy;
   assign wx = CORDIC_W'(in_x);
   assign wy = CORDIC_W'(in_y);

   // fold the left half plane onto the right one
   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
         if (wx < 0) begin
            if (wy >= 0) begin
               x_ff[0] <= wy;
               y_ff[0] <= -wx;
               z_ff[0] <= HALF_PI_Q24;
            end else begin
               x_ff[0] <= -wy;
               y_ff[0] <= wx;
               z_ff[0] <= -HALF_PI_Q24;
            end
         end else begin
            x_ff[0] <= wx;
            y_ff[0] <= wy;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic signed [CORDIC_W-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (enable) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + atan_q24(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - atan_q24(i);
            end
         end
      end
   end

   assign angle = zero_ff[CORDIC_STEPS] ? '0 : z_ff[CORDIC_STEPS];

endmodule

[hdl/two_link_planar_ik.sv]
// Top level of the two-link planar leg inverse kinematics pipeline.
//
// Usage:
//  - Requests enter on req_* (valid/stall): a planar foot target in Q16 meters and
//    the elbow branch. Each request yields exactly one response on rsp_*:
//    hip and knee pitch in Q12 radians, or zero angles with rsp_unreachable
//    set when the target is out of reach, at the origin, or a link is zero.
//  - Link lengths and joint offsets are written through csr_* (index 0..3)
//    while no request is in flight; a write takes effect at once.
//  - A new request is taken every cycle while req_stall is low.
//  - The path: squares, radius square root (32 stages), law-of-cosines
//    setup, second square root (32 stages), then three parallel CORDICs.
//  - The whole pipeline advances together; when rsp_stall holds a valid
//    response, every stage holds and req_stall rises, so nothing is lost
//    or repeated. An empty output register never blocks the pipeline.
//  - Reset (synchronous, active high) empties the pipeline and restores
//    the register defaults.
module two_link_planar_ik (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [17:0] req_target_x,
   input  logic signed [17:0] req_target_y,
   input  logic               req_elbow_up,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [16:0] rsp_hip_angle,
   output logic signed [16:0] rsp_knee_angle,
   output logic               rsp_unreachable
);
   import tlik_pkg::*;

   localparam int CORDIC_LAT = CORDIC_STEPS + 1;

   // configuration registers
   logic [15:0]        upper_len_ff, lower_len_ff;
   logic signed [14:0] hip_off_ff, knee_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_len_ff <= 16'd18759;
         lower_len_ff <= 16'd19648;
         hip_off_ff   <= 15'sd7177;
         knee_off_ff  <= 15'sd907;
      end else if (csr_write) begin
         case (csr_index)
            CSR_UPPER_LEN: upper_len_ff <= csr_write_data;
            CSR_LOWER_LEN: lower_len_ff <= csr_write_data;
            CSR_HIP_OFF:   hip_off_ff   <= csr_write_data[14:0];
            CSR_KNEE_OFF:  knee_off_ff  <= csr_write_data[14:0];
            default: ;
         endcase
      end
   end

   // advance the whole pipeline unless a held response blocks it
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // stage 1: squares and link products
   logic               v1_ff;
   side_type           sd1_ff;
   logic [34:0]        xx_ff, yy_ff;
   logic [31:0]        l1s_ff, l2s_ff, l12_ff;
   logic signed [35:0] xx_full, yy_full;

   assign xx_full = req_target_x * req_target_x;
   assign yy_full = req_target_y * req_target_y;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sd1_ff.x    <= req_target_x;
         sd1_ff.y    <= req_target_y;
         sd1_ff.up   <= req_elbow_up;
         sd1_ff.fail <= 1'b0;
         xx_ff       <= xx_full[34:0];
         yy_ff       <= yy_full[34:0];
         l1s_ff      <= upper_len_ff * upper_len_ff;
         l2s_ff      <= lower_len_ff * lower_len_ff;
         l12_ff      <= upper_len_ff * lower_len_ff;
      end
   end

   // stage 2: radius squared, knee and shoulder cosine numerators and reach check
   logic               v2_ff;
   side_type           sd2_ff;
   logic [35:0]        r2_ff;
   logic signed [37:0] nk_ff, nb_ff;
   logic [32:0]        mk_ff;
   logic [35:0]        r2_sum;
   logic signed [37:0] nk_sum, nb_sum;
   logic signed [38:0] mk_s;
   logic               fail_now;

   always_comb begin
      r2_sum   = 36'(xx_ff) + 36'(yy_ff);
      nk_sum   = 38'(r2_sum) - 38'(l1s_ff) - 38'(l2s_ff);
      nb_sum   = 38'(r2_sum) + 38'(l1s_ff) - 38'(l2s_ff);
      mk_s     = 39'({l12_ff, 1'b0});
      fail_now = (r2_sum == '0) || (l12_ff == '0) || (39'(nk_sum) > mk_s)
                 || (-39'(nk_sum) > mk_s);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sd2_ff.x    <= sd1_ff.x;
         sd2_ff.y    <= sd1_ff.y;
         sd2_ff.up   <= sd1_ff.up;
         sd2_ff.fail <= fail_now;
         r2_ff       <= r2_sum;
         nk_ff       <= nk_sum;
         nb_ff       <= nb_sum;
         mk_ff       <= {l12_ff, 1'b0};
      end
   end

   // radius square root; hold the rest alongside
   logic [31:0] r_root;
   tlik_isqrt u_radius (
      .clock    (clock),
      .enable   (advance),
      .radicand (64'(r2_ff)),
      .root     (r_root)
   );

   logic               vd1_ff  [SQRT_STAGES];
   side_type           sdd1_ff [SQRT_STAGES];
   logic signed [37:0] nkd_ff  [SQRT_STAGES];
   logic signed [37:0] nbd_ff  [SQRT_STAGES];
   logic [32:0]        mkd_ff  [SQRT_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STAGES; k++) vd1_ff[k] <= 1'b0;
      end else if (advance) begin
         vd1_ff[0] <= v2_ff;
         for (int k = 1; k < SQRT_STAGES; k++) vd1_ff[k] <= vd1_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sdd1_ff[0] <= sd2_ff;
         nkd_ff[0]  <= nk_ff;
         nbd_ff[0]  <= nb_ff;
         mkd_ff[0]  <= mk_ff;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            sdd1_ff[k] <= sdd1_ff[k-1];
            nkd_ff[k]  <= nkd_ff[k-1];
            nbd_ff[k]  <= nbd_ff[k-1];
            mkd_ff[k]  <= mkd_ff[k-1];
         end
      end
   end

   // stage 3: shoulder cosine denominator 2*L1*r; lane 0 knee, lane 1 shoulder
   logic               v3_ff;
   side_type           sd3_ff;
   logic signed [37:0] n3_ff [2];
   logic [34:0]        m3_ff [2];
   logic [33:0]        l1r;

   assign l1r = upper_len_ff * r_root[17:0];

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= vd1_ff[SQRT_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sd3_ff   <= sdd1_ff[SQRT_STAGES-1];
         n3_ff[0] <= nkd_ff[SQRT_STAGES-1];
         m3_ff[0] <= 35'(mkd_ff[SQRT_STAGES-1]);
         n3_ff[1] <= nbd_ff[SQRT_STAGES-1];
         m3_ff[1] <= {l1r, 1'b0};
      end
   end

   // stage 4: clamp the cosine and scale both terms below 2^30
   logic               v4_ff;
   side_type           sd4_ff;
   logic signed [31:0] n4_ff [2];
   logic [29:0]        m4_ff [2];

   for (genvar ln = 0; ln < 2; ln++) begin : g_norm
      logic signed [38:0] nc;
      logic signed [38:0] mc;
      logic [2:0]         sh;
      logic signed [38:0] ns;
      logic [34:0]        ms;
      always_comb begin
         mc = 39'(m3_ff[ln]);
         nc = 39'(n3_ff[ln]);
         if (nc > mc) nc = mc;
         if (nc < -mc) nc = -mc;
         sh = '0;
         for (int b = 30; b < 35; b++) begin
            if (m3_ff[ln][b]) sh = 3'(b - 29);
         end
         ns = nc >>> sh;
         ms = m3_ff[ln] >> sh;
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            n4_ff[ln] <= ns[31:0];
            m4_ff[ln] <= ms[29:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) sd4_ff <= sd3_ff;
   end

   // stage 5: squares of the scaled terms
   logic               v5_ff;
   side_type           sd5_ff;
   logic signed [31:0] n5_ff  [2];
   logic [59:0]        mm5_ff [2];
   logic signed [63:0] nn5_ff [2];

   // stage 6: sine term squared, negative taken as zero
   logic               v6_ff;
   side_type           sd6_ff;
   logic signed [31:0] n6_ff [2];
   logic [63:0]        d6_ff [2];
   logic [31:0]        s_root [2];

   for (genvar ln = 0; ln < 2; ln++) begin : g_sine
      logic signed [64:0] dif;
      assign dif = 65'(mm5_ff[ln]) - 65'(nn5_ff[ln]);
      always_ff @(posedge clock) begin
         if (advance) begin
            n5_ff[ln]  <= n4_ff[ln];
            mm5_ff[ln] <= m4_ff[ln] * m4_ff[ln];
            nn5_ff[ln] <= n4_ff[ln] * n4_ff[ln];
            n6_ff[ln]  <= n5_ff[ln];
            d6_ff[ln]  <= dif[64] ? '0 : dif[63:0];
         end
      end
      tlik_isqrt u_sine (
         .clock    (clock),
         .enable   (advance),
         .radicand (d6_ff[ln]),
         .root     (s_root[ln])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sd5_ff <= sd4_ff;
         sd6_ff <= sd5_ff;
      end
   end

   // hold cosine terms and sideband during the second square root
   logic               vd2_ff  [SQRT_STAGES];
   side_type           sdd2_ff [SQRT_STAGES];
   logic signed [31:0] nd2_ff  [2][SQRT_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STAGES; k++) vd2_ff[k] <= 1'b0;
      end else if (advance) begin
         vd2_ff[0] <= v6_ff;
         for (int k = 1; k < SQRT_STAGES; k++) vd2_ff[k] <= vd2_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sdd2_ff[0]   <= sd6_ff;
         nd2_ff[0][0] <= n6_ff[0];
         nd2_ff[1][0] <= n6_ff[1];
         for (int k = 1; k < SQRT_STAGES; k++) begin
            sdd2_ff[k]   <= sdd2_ff[k-1];
            nd2_ff[0][k] <= nd2_ff[0][k-1];
            nd2_ff[1][k] <= nd2_ff[1][k-1];
         end
      end
   end

   // three arcs in parallel: knee, shoulder and target bearing
   side_type  sdc;
   angle_type q2_z, beta_z, gamma_z;

   assign sdc = sdd2_ff[SQRT_STAGES-1];

   tlik_cordic u_knee (
      .clock  (clock),
      .enable (advance),
      .in_x   (nd2_ff[0][SQRT_STAGES-1]),
      .in_y   (s_root[0]),
      .angle  (q2_z)
   );

   tlik_cordic u_shoulder (
      .clock  (clock),
      .enable (advance),
      .in_x   (nd2_ff[1][SQRT_STAGES-1]),
      .in_y   (s_root[1]),
      .angle  (beta_z)
   );

   // sign-extend the Q28 target so the left half plane stays negative
   tlik_cordic u_bearing (
      .clock  (clock),
      .enable (advance),
      .in_x   ({{2{sdc.x[17]}}, sdc.x, 12'd0}),
      .in_y   ({{2{sdc.y[17]}}, sdc.y, 12'd0}),
      .angle  (gamma_z)
   );

   logic     vd3_ff  [CORDIC_LAT];
   side_type sdd3_ff [CORDIC_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CORDIC_LAT; k++) vd3_ff[k] <= 1'b0;
      end else if (advance) begin
         vd3_ff[0] <= vd2_ff[SQRT_STAGES-1];
         for (int k = 1; k < CORDIC_LAT; k++) vd3_ff[k] <= vd3_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sdd3_ff[0] <= sdc;
         for (int k = 1; k < CORDIC_LAT; k++) sdd3_ff[k] <= sdd3_ff[k-1];
      end
   end

   // final stage: branch sign, round to Q12, add offsets
   side_type           sdf;
   angle_type          q2_s, beta_s;
   logic signed [28:0] hip_z;
   logic signed [28:0] hip_r;
   logic signed [28:0] knee_r;
   logic signed [17:0] hip_sum, knee_sum;
   logic               rsp_valid_ff;
   logic signed [16:0] rsp_hip_ff, rsp_knee_ff;
   logic               rsp_unreach_ff;

   always_comb begin
      sdf      = sdd3_ff[CORDIC_LAT-1];
      q2_s     = sdf.up ? q2_z : -q2_z;
      beta_s   = sdf.up ? beta_z : -beta_z;
      hip_z    = 29'(gamma_z) - 29'(beta_s);
      hip_r    = (hip_z + 29'sd2048) >>> 12;
      knee_r   = (29'(q2_s) + 29'sd2048) >>> 12;
      hip_sum  = 18'(hip_r) + 18'(hip_off_ff);
      knee_sum = 18'(knee_off_ff) - 18'(knee_r);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= vd3_ff[CORDIC_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_unreach_ff <= sdf.fail;
         rsp_hip_ff     <= sdf.fail ? '0 : hip_sum[16:0];
         rsp_knee_ff    <= sdf.fail ? '0 : knee_sum[16:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hip_angle   = rsp_hip_ff;
   assign rsp_knee_angle  = rsp_knee_ff;
   assign rsp_unreachable = rsp_unreach_ff;

   // an unreachable target always reports zero angles
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_unreach_ff |-> rsp_hip_ff == '0 && rsp_knee_ff == '0)
      else $error("unreachable response with nonzero angles");

   // a blocked pipeline holds the valid flags of stages 1 and 2
   assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(v1_ff) && $stable(v2_ff))
      else $error("pipeline moved while stalled");

   // reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid right after reset");

endmodule
